// ----- rtl/core/cllt_pkg.sv -----
// ----------------------------------------------------------------------------
// cllt_pkg
// Shared constants, command codes and controller/datapath interface types
// for the two-line character LCD terminal front end.
// ----------------------------------------------------------------------------
`default_nettype none

package cllt_pkg;

	// Line geometry
	localparam int LINE_WIDTH = 16;
	localparam int COL_W      = $clog2(LINE_WIDTH + 1);
	localparam int IDX_W      = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

	// Input command codes
	localparam logic [1:0] CMD_PUT        = 2'd0;
	localparam logic [1:0] CMD_CLEAR_ALL  = 2'd1;
	localparam logic [1:0] CMD_CLEAR_LINE = 2'd2;

	// Controller bytes
	localparam logic [7:0] LCD_CLEAR_DISPLAY = 8'h01;
	localparam logic [7:0] LCD_BASE_LINE0    = 8'h80;
	localparam logic [7:0] LCD_BASE_LINE1    = 8'hC0;
	localparam logic [7:0] CH_SPACE          = 8'h20;
	localparam logic [7:0] CH_QUEST          = 8'h3F;

	// Control characters
	localparam logic [15:0] CH_NL  = 16'd10;
	localparam logic [15:0] CH_TAB = 16'd9;
	localparam logic [15:0] CH_FF  = 16'd12;
	localparam logic [15:0] CH_CR  = 16'd13;

	// Register-select values
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_COL_ZERO,
		OP_CLR_ALL,
		OP_CLR_BASE,
		OP_CLR_SPACE,
		OP_SCR_BASE,
		OP_SCR_CHAR,
		OP_SCR_SPACE,
		OP_PUT_ADDR,
		OP_PUT_DATA
	} dp_op_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       is_nl;
		logic       is_cr;
		logic       is_ff;
		logic       full;
		logic       idx_last;
		logic       emit_ok;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/cllt_ctrl.sv -----
// ----------------------------------------------------------------------------
// cllt_ctrl
// Command sequencer: takes one command, then steps through its run of
// controller writes, one write per cycle whenever the output slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module cllt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire cllt_pkg::dp_status_t sts,
	output cllt_pkg::dp_op_t        op
);
	import cllt_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b0000000001,
		ST_DISPATCH  = 10'b0000000010,
		ST_CLR_ALL   = 10'b0000000100,
		ST_CLR_BASE  = 10'b0000001000,
		ST_CLR_SPACE = 10'b0000010000,
		ST_SCR_BASE  = 10'b0000100000,
		ST_SCR_CHAR  = 10'b0001000000,
		ST_SCR_SPACE = 10'b0010000000,
		ST_PUT_ADDR  = 10'b0100000000,
		ST_PUT_DATA  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	// Next state and datapath operation
	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op      = OP_LATCH;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.cmd)
					CMD_PUT: begin
						if (sts.is_nl) begin
							state_d = ST_IDLE;
						end else if (sts.is_cr) begin
							op      = OP_COL_ZERO;
							state_d = ST_IDLE;
						end else if (sts.is_ff) begin
							state_d = ST_CLR_BASE;
						end else if (sts.full) begin
							state_d = ST_SCR_BASE;
						end else begin
							state_d = ST_PUT_ADDR;
						end
					end
					CMD_CLEAR_ALL:  state_d = ST_CLR_ALL;
					CMD_CLEAR_LINE: state_d = ST_CLR_BASE;
					default:        state_d = ST_IDLE;
				endcase
			end
			ST_CLR_ALL: begin
				if (sts.emit_ok) begin
					op      = OP_CLR_ALL;
					state_d = ST_IDLE;
				end
			end
			ST_CLR_BASE: begin
				if (sts.emit_ok) begin
					op      = OP_CLR_BASE;
					state_d = ST_CLR_SPACE;
				end
			end
			ST_CLR_SPACE: begin
				if (sts.emit_ok) begin
					op = OP_CLR_SPACE;
					if (sts.idx_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SCR_BASE: begin
				if (sts.emit_ok) begin
					op      = OP_SCR_BASE;
					state_d = (LINE_WIDTH > 1) ? ST_SCR_CHAR : ST_SCR_SPACE;
				end
			end
			ST_SCR_CHAR: begin
				if (sts.emit_ok) begin
					op = OP_SCR_CHAR;
					if (sts.idx_last) begin
						state_d = ST_SCR_SPACE;
					end
				end
			end
			ST_SCR_SPACE: begin
				if (sts.emit_ok) begin
					op      = OP_SCR_SPACE;
					state_d = ST_PUT_ADDR;
				end
			end
			ST_PUT_ADDR: begin
				if (sts.emit_ok) begin
					op      = OP_PUT_ADDR;
					state_d = ST_PUT_DATA;
				end
			end
			ST_PUT_DATA: begin
				if (sts.emit_ok) begin
					op      = OP_PUT_DATA;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/cllt_dp.sv -----
// ----------------------------------------------------------------------------
// cllt_dp
// Datapath: latched command, shadow text, line columns, run index and the
// output register holding one controller write beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cllt_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         cmd,
	input  wire logic               line_sel,
	input  wire logic signed [15:0] char_code,
	input  wire cllt_pkg::dp_op_t   op,
	output cllt_pkg::dp_status_t    sts,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    reg_select,
	output logic [7:0]              bus_byte,
	output logic                    last
);
	import cllt_pkg::*;

	logic [1:0]       cmd_q;
	logic             line_q;
	logic             nl_q, cr_q, ff_q;
	logic [7:0]       char_q;
	logic [7:0]       shadow_q [2][LINE_WIDTH];
	logic [COL_W-1:0] col_q [2];
	logic [IDX_W-1:0] idx_q;

	logic             out_valid_q;
	logic             rs_q;
	logic [7:0]       byte_q;
	logic             last_q;

	logic             emit;
	logic             emit_rs;
	logic [7:0]       emit_byte;
	logic             emit_last;
	logic [7:0]       base;
	logic [7:0]       rd_char;
	logic [COL_W-1:0] col_cur;
	logic             idx_last;
	logic [7:0]       mapped_char;

	// Character mapping at accept time
	always_comb begin
		if (char_code == CH_TAB) begin
			mapped_char = CH_SPACE;
		end else if (char_code[15:8] != 8'd0) begin
			mapped_char = CH_QUEST;
		end else begin
			mapped_char = char_code[7:0];
		end
	end

	assign base     = line_q ? LCD_BASE_LINE1 : LCD_BASE_LINE0;
	assign col_cur  = col_q[line_q];
	assign rd_char  = shadow_q[line_q][idx_q];
	assign idx_last = (idx_q == IDX_W'(LINE_WIDTH - 1));

	// Write beat selection
	always_comb begin
		emit      = 1'b1;
		emit_rs   = RS_DATA;
		emit_byte = CH_SPACE;
		emit_last = 1'b0;
		case (op) inside
			OP_CLR_ALL: begin
				emit_rs   = RS_CMD;
				emit_byte = LCD_CLEAR_DISPLAY;
				emit_last = 1'b1;
			end
			OP_CLR_BASE, OP_SCR_BASE: begin
				emit_rs   = RS_CMD;
				emit_byte = base;
			end
			OP_CLR_SPACE: emit_last = idx_last;
			OP_SCR_CHAR:  emit_byte = rd_char;
			OP_SCR_SPACE: emit_byte = CH_SPACE;
			OP_PUT_ADDR: begin
				emit_rs   = RS_CMD;
				emit_byte = base | 8'(col_cur);
			end
			OP_PUT_DATA: begin
				emit_byte = char_q;
				emit_last = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	assign sts.cmd      = cmd_q;
	assign sts.is_nl    = nl_q;
	assign sts.is_cr    = cr_q;
	assign sts.is_ff    = ff_q;
	assign sts.full     = (col_cur == COL_W'(LINE_WIDTH));
	assign sts.idx_last = idx_last;
	assign sts.emit_ok  = !out_valid_q || !out_stall;

	// Latched command fields
	always_ff @(posedge clk) begin
		if (op == OP_LATCH) begin
			cmd_q  <= cmd;
			line_q <= line_sel;
			nl_q   <= (char_code == CH_NL);
			cr_q   <= (char_code == CH_CR);
			ff_q   <= (char_code == CH_FF);
			char_q <= mapped_char;
		end
	end

	// Shadow text, columns and run index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 2; l++) begin
				col_q[l] <= '0;
				for (int i = 0; i < LINE_WIDTH; i++) begin
					shadow_q[l][i] <= CH_SPACE;
				end
			end
			idx_q <= '0;
		end else begin
			case (op)
				OP_COL_ZERO: col_q[line_q] <= '0;
				OP_CLR_ALL: begin
					for (int l = 0; l < 2; l++) begin
						col_q[l] <= '0;
						for (int i = 0; i < LINE_WIDTH; i++) begin
							shadow_q[l][i] <= CH_SPACE;
						end
					end
				end
				OP_CLR_BASE: idx_q <= '0;
				OP_CLR_SPACE: begin
					shadow_q[line_q][idx_q] <= CH_SPACE;
					idx_q <= idx_q + 1'b1;
					if (idx_last) begin
						col_q[line_q] <= '0;
					end
				end
				OP_SCR_BASE: idx_q <= IDX_W'(1);
				OP_SCR_CHAR: begin
					// shift one place left
					shadow_q[line_q][idx_q - 1'b1] <= rd_char;
					idx_q <= idx_q + 1'b1;
				end
				OP_SCR_SPACE: col_q[line_q] <= COL_W'(LINE_WIDTH - 1);
				OP_PUT_DATA: begin
					shadow_q[line_q][col_cur[IDX_W-1:0]] <= char_q;
					col_q[line_q] <= col_cur + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (emit) begin
			rs_q   <= emit_rs;
			byte_q <= emit_byte;
			last_q <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign reg_select = rs_q;
	assign bus_byte   = byte_q;
	assign last       = last_q;

	// Columns never pass the line width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q[0] <= COL_W'(LINE_WIDTH)) && (col_q[1] <= COL_W'(LINE_WIDTH)))
		else $error("line column beyond line width");

	// A new beat never overwrites one still stalled at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit && out_valid_q && out_stall))
		else $error("beat issued into a stalled output register");

	// The character write closes a put run
	a_put_last: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_PUT_DATA) |=> (out_valid_q && last_q && rs_q == RS_DATA))
		else $error("put data beat not marked last");

	// After a scroll the column sits at the last position
	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_SCR_SPACE) |=> (col_q[line_q] == COL_W'(LINE_WIDTH - 1)))
		else $error("scroll left column out of place");

endmodule

`default_nettype wire

// ----- rtl/core/char_lcd_line_terminal.sv -----
// ----------------------------------------------------------------------------
// char_lcd_line_terminal
// Two-line character LCD terminal front end: turns put/clear commands into
// runs of LCD controller writes, keeping a shadow text buffer per line.
// ----------------------------------------------------------------------------
// Path: a command is latched at accept and decoded before its writes are registered.
// Throughput: one write beat per cycle while the output is not stalled; a command
//   holds the sequencer until its last write beat is issued.
// Run lengths: put 2 beats, put on a full line LINE_WIDTH+3, line clear
//   LINE_WIDTH+1, display clear 1; newline, carriage return and unused codes 0.
// Reset: asynchronous; columns go to 0 and shadow text to spaces at once.
`default_nettype none

module char_lcd_line_terminal (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic               line_sel,
	input  wire logic signed [15:0] char_code,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    reg_select,
	output logic [7:0]              bus_byte,
	output logic                    last
);
	import cllt_pkg::*;

	dp_op_t     op;
	dp_status_t sts;

	// Command sequencer
	cllt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.op       (op)
	);

	// Shadow text and output datapath
	cllt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.line_sel   (line_sel),
		.char_code  (char_code),
		.op         (op),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.reg_select (reg_select),
		.bus_byte   (bus_byte),
		.last       (last)
	);

endmodule

`default_nettype wire

// ----- sim/tb_char_lcd_line_terminal.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_line_terminal
// Self-checking bench for the two-line LCD terminal front end. A scoreboard
// object keeps its own shadow text and cursor columns, predicts the
// controller writes of every accepted command and checks each write beat in
// order. Directed commands cover code extremes, control characters, scrolling
// and every command; random traffic with random idling on both sides follows.
// ----------------------------------------------------------------------------

module tb_char_lcd_line_terminal;
	import cllt_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         RANDOM_BEATS = 295;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         HOLD_CYCLES  = 400;

	typedef struct packed {
		logic       rs;
		logic [7:0] data;
		logic       is_last;
	} lcd_write_t;

	// Shadow-text model of the terminal plus the queue of writes still owed
	class lcd_write_board;
		lcd_write_t  due_writes[$];
		lcd_write_t  run_writes[$];
		logic [7:0]  shadow[2][LINE_WIDTH];
		int unsigned column[2];
		int unsigned mismatches;

		function new();
			foreach (shadow[l, i])
				shadow[l][i] = CH_SPACE;
			column[0]  = 0;
			column[1]  = 0;
			mismatches = 0;
		endfunction

		function logic [7:0] line_base(logic l);
			return l ? LCD_BASE_LINE1 : LCD_BASE_LINE0;
		endfunction

		function void add_write(logic rs, logic [7:0] data);
			run_writes.push_back('{rs: rs, data: data, is_last: 1'b0});
		endfunction

		function void blank_line(logic l);
			add_write(RS_CMD, line_base(l));
			for (int i = 0; i < LINE_WIDTH; i++) begin
				add_write(RS_DATA, CH_SPACE);
				shadow[l][i] = CH_SPACE;
			end
			column[l] = 0;
		endfunction

		function int pending();
			return due_writes.size();
		endfunction

		// Work out the write run of one accepted command
		function void note_command(logic [1:0] c, logic l, logic signed [15:0] code);
			int          value;
			int unsigned col;
			logic [7:0]  ch;
			value = code;
			run_writes.delete();
			case (c)
				CMD_PUT: begin
					if (code == CH_NL) begin
						// newline writes nothing
					end else if (code == CH_CR) begin
						column[l] = 0;
					end else if (code == CH_FF) begin
						blank_line(l);
					end else begin
						if (code == CH_TAB)
							ch = CH_SPACE;
						else if (value < 0 || value > 255)
							ch = CH_QUEST;
						else
							ch = value[7:0];
						// full line: shift the shadow left, then a trailing space
						if (column[l] >= LINE_WIDTH && column[l] > 0) begin
							add_write(RS_CMD, line_base(l));
							for (int i = 1; i < column[l] && i < LINE_WIDTH; i++) begin
								add_write(RS_DATA, shadow[l][i]);
								shadow[l][i-1] = shadow[l][i];
							end
							add_write(RS_DATA, CH_SPACE);
							column[l] = column[l] - 1;
						end
						col = (column[l] >= LINE_WIDTH) ? LINE_WIDTH - 1 : column[l];
						add_write(RS_CMD, line_base(l) | 8'(col));
						add_write(RS_DATA, ch);
						shadow[l][col] = ch;
						column[l] = col + 1;
					end
				end
				CMD_CLEAR_ALL: begin
					add_write(RS_CMD, LCD_CLEAR_DISPLAY);
					foreach (shadow[k, i])
						shadow[k][i] = CH_SPACE;
					column[0] = 0;
					column[1] = 0;
				end
				CMD_CLEAR_LINE: blank_line(l);
				default: ;
			endcase
			if (run_writes.size() > 0)
				run_writes[run_writes.size()-1].is_last = 1'b1;
			foreach (run_writes[i])
				due_writes.push_back(run_writes[i]);
		endfunction

		// Compare one write beat against the oldest expected write
		function void check_write(logic rs, logic [7:0] data, logic is_last);
			lcd_write_t want;
			if (due_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected write: rs=%0d byte=%02h last=%0d",
						rs, data, is_last);
			end else begin
				want = due_writes.pop_front();
				if (want.rs !== rs || want.data !== data || want.is_last !== is_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"write mismatch: expected rs=%0d byte=%02h last=%0d,",
							" got rs=%0d byte=%02h last=%0d"},
							want.rs, want.data, want.is_last, rs, data, is_last);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic               line_sel;
	logic signed [15:0] char_code;
	logic               out_valid;
	logic               out_stall;
	logic               reg_select;
	logic [7:0]         bus_byte;
	logic               last;

	lcd_write_board board = new();
	bit             steady;
	bit             hold_request;

	char_lcd_line_terminal u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.line_sel   (line_sel),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.reg_select (reg_select),
		.bus_byte   (bus_byte),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none during steady stretches
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Beat monitors
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_command(cmd, line_sel, char_code);
		if (arst_n && out_valid && !out_stall)
			board.check_write(reg_select, bus_byte, last);
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	// Offer one command beat and hold it until taken; called at a falling edge
	task automatic send_command(input logic [1:0] c, input logic l,
			input logic signed [15:0] code);
		int unsigned gap;
		in_valid  <= 1'b1;
		cmd       <= c;
		line_sel  <= l;
		char_code <= code;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (board.pending() != 0);
	endtask

	// Stimulus
	initial begin
		int unsigned        r;
		int unsigned        counted;
		logic [1:0]         c;
		logic               l;
		logic signed [15:0] code;
		in_valid     = 1'b0;
		cmd          = CMD_PUT;
		line_sel     = 1'b0;
		char_code    = '0;
		steady       = 1'b0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Code extremes on line 1 until it is full, then one more to scroll
		send_command(CMD_PUT, 1'b1, 16'sd0);
		send_command(CMD_PUT, 1'b1, 16'sd255);
		send_command(CMD_PUT, 1'b1, 16'sd256);
		send_command(CMD_PUT, 1'b1, -16'sd1);
		send_command(CMD_PUT, 1'b1, 16'sh8000);
		send_command(CMD_PUT, 1'b1, 16'sh7FFF);
		send_command(CMD_PUT, 1'b1, CH_TAB);
		for (int i = 0; i < 10; i++)
			send_command(CMD_PUT, 1'b1, 16'(16'h41 + i));
		// newline, carriage return, writes from column zero
		send_command(CMD_PUT, 1'b1, CH_NL);
		send_command(CMD_PUT, 1'b1, CH_CR);
		send_command(CMD_PUT, 1'b1, 16'h4B);
		send_command(CMD_PUT, 1'b1, 16'h4C);
		// form feed, unused code, both clears
		send_command(CMD_PUT, 1'b0, 16'h61);
		send_command(CMD_PUT, 1'b0, CH_FF);
		send_command(CMD_UNUSED, 1'b1, 16'shFFFF);
		send_command(CMD_CLEAR_LINE, 1'b1, 16'sh0000);
		send_command(CMD_CLEAR_LINE, 1'b0, 16'shFFFF);
		send_command(CMD_CLEAR_ALL, 1'b1, 16'sh5A5A);
		// sender pause until every write is out
		wait_drained();

		// Random traffic: mostly printable puts so the lines fill and scroll
		counted = 0;
		while (counted < RANDOM_BEATS) begin
			steady = (counted >= 80 && counted < 140);
			if (counted == 200 && !hold_request)
				hold_request = 1'b1;
			r    = $urandom_range(0, 199);
			l    = 1'($urandom_range(0, 1));
			c    = CMD_PUT;
			code = 16'($urandom_range(32, 126));
			if (r < 8) begin
				case ($urandom_range(0, 3))
					0:       code = CH_TAB;
					1:       code = CH_NL;
					2:       code = CH_FF;
					default: code = CH_CR;
				endcase
			end else if (r < 20) begin
				code = 16'($urandom);
			end else if (r < 28) begin
				code = 16'($urandom_range(0, 255));
			end else if (r < 32) begin
				c    = CMD_CLEAR_LINE;
				code = 16'($urandom);
			end else if (r < 33) begin
				c    = CMD_CLEAR_ALL;
				code = 16'($urandom);
			end else if (r < 37) begin
				c    = CMD_UNUSED;
				code = 16'($urandom);
			end
			send_command(c, l, code);
			if (!(c == CMD_UNUSED || (c == CMD_PUT && code == CH_NL)))
				counted++;
		end
		steady = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#8ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
